>>> rtl/arwf_pkg.sv
// Shared constants, codes and types for the anti-replay window filter.
package arwf_pkg;

   localparam int NUM_SENDERS = 16;
   localparam int WINDOW_BITS = 64;
   localparam int IDX_W       = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
   localparam int SH_W        = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

   typedef enum logic [2:0] {
      STAT_OK     = 3'd0,
      STAT_BAD_ID = 3'd1,
      STAT_ZERO   = 3'd2,
      STAT_OLD    = 3'd3,
      STAT_DUP    = 3'd4,
      STAT_RESET  = 3'd5
   } status_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  remote_id;
      logic [31:0] seq;
   } item_type;

   typedef struct packed {
      logic                   vld;
      logic [31:0]            hi;
      logic [WINDOW_BITS-1:0] bm;
   } rec_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      rec_type          rec;
   } wr_type;

   typedef struct packed {
      logic        accepted;
      status_type  status;
      logic [31:0] max_seq;
      logic        initialized;
   } rsp_type;

endpackage

>>> rtl/arwf_rec_mem.sv
// Per-sender record store: synchronous memory plus reset-cleared valid flags.
module arwf_rec_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [arwf_pkg::IDX_W-1:0] rd_idx,
   output arwf_pkg::rec_type          rd_rec,
   input  arwf_pkg::wr_type           wr
);
   import arwf_pkg::*;

   logic [31:0]            hi_mem [NUM_SENDERS];
   logic [WINDOW_BITS-1:0] bm_mem [NUM_SENDERS];
   logic [NUM_SENDERS-1:0] vld_ff;
   logic [31:0]            hi_rd_ff;
   logic [WINDOW_BITS-1:0] bm_rd_ff;
   logic                   vld_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         hi_mem[wr.idx] <= wr.rec.hi;
         bm_mem[wr.idx] <= wr.rec.bm;
      end
      if (rd_en) begin
         hi_rd_ff <= hi_mem[rd_idx];
         bm_rd_ff <= bm_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.idx] <= wr.rec.vld;
         end
         if (rd_en) begin
            vld_rd_ff <= vld_ff[rd_idx];
         end
      end
   end

   // an entry that is not valid reads as its cleared value
   always_comb begin
      rd_rec.vld = vld_rd_ff;
      rd_rec.hi  = vld_rd_ff ? hi_rd_ff : 32'd0;
      rd_rec.bm  = vld_rd_ff ? bm_rd_ff : '0;
   end

endmodule

>>> rtl/arwf_check.sv
// Window check and record update for one word against its sender's record.
module arwf_check (
   input  arwf_pkg::item_type item,
   input  arwf_pkg::rec_type  rec,
   output arwf_pkg::wr_type   wr,
   output arwf_pkg::rsp_type  rsp
);
   import arwf_pkg::*;

   logic        id_ok;
   logic        ahead;
   logic [31:0] d_up;
   logic [31:0] d_dn;
   logic        up_in_win;
   logic        dn_in_win;

   always_comb begin
      id_ok     = (item.remote_id != 8'd0) && (item.remote_id <= 8'(NUM_SENDERS));
      ahead     = item.seq > rec.hi;
      d_up      = item.seq - rec.hi;
      d_dn      = rec.hi - item.seq;
      up_in_win = d_up < 32'(WINDOW_BITS);
      dn_in_win = d_dn < 32'(WINDOW_BITS);

      wr.en           = 1'b0;
      wr.idx          = IDX_W'(item.remote_id - 8'd1);
      wr.rec          = rec;
      rsp.accepted    = 1'b0;
      rsp.status      = STAT_OK;
      rsp.max_seq     = rec.hi;
      rsp.initialized = rec.vld;

      if (!id_ok) begin
         rsp.status      = STAT_BAD_ID;
         rsp.max_seq     = 32'd0;
         rsp.initialized = 1'b0;
      end else if (item.cmd) begin
         wr.en           = 1'b1;
         wr.rec          = '0;
         rsp.status      = STAT_RESET;
         rsp.max_seq     = 32'd0;
         rsp.initialized = 1'b0;
      end else if (item.seq == 32'd0) begin
         rsp.status = STAT_ZERO;
      end else if (!rec.vld) begin
         wr.en           = 1'b1;
         wr.rec.vld      = 1'b1;
         wr.rec.hi       = item.seq;
         wr.rec.bm       = WINDOW_BITS'(1);
         rsp.accepted    = 1'b1;
         rsp.max_seq     = item.seq;
         rsp.initialized = 1'b1;
      end else if (ahead) begin
         // slide the window up; a jump past its width starts it afresh
         wr.en        = 1'b1;
         wr.rec.hi    = item.seq;
         wr.rec.bm    = up_in_win ? ((rec.bm << d_up[SH_W-1:0]) | WINDOW_BITS'(1))
                                  : WINDOW_BITS'(1);
         rsp.accepted = 1'b1;
         rsp.max_seq  = item.seq;
      end else if (!dn_in_win) begin
         rsp.status = STAT_OLD;
      end else if (rec.bm[d_dn[SH_W-1:0]]) begin
         rsp.status = STAT_DUP;
      end else begin
         wr.en        = 1'b1;
         wr.rec.bm    = rec.bm | (WINDOW_BITS'(1) << d_dn[SH_W-1:0]);
         rsp.accepted = 1'b1;
      end
   end

endmodule

>>> rtl/anti_replay_window_filter.sv
// Top level of the anti-replay window filter: control, record store and result register.
//
// Usage:
//   Request channel (req_valid / req_stall): one word carries req_cmd
//   (0 = validate a packet, 1 = clear that sender's record), req_remote_id
//   (1..16) and req_seq. A word is taken at a rising edge with req_valid high
//   and req_stall low.
//   Response channel (rsp_valid / rsp_stall): exactly one word per request,
//   in request order, with rsp_accepted, rsp_status, rsp_max_seq and
//   rsp_initialized describing the sender's record after the request.
//   Steps: a request is taken only in the idle state, and the next one only
//   after its response is loaded. The read step fetches the sender's record
//   from the record memory; the check step checks the window, loads the
//   response and writes the record back, so the next read always sees it.
//   Reset: synchronous and active high; all sender records read as cleared
//   right after reset, with no clearing pass.
//   Stall: a response held by rsp_stall stays in the output register; the
//   next request is still taken and read, and waits in the check step until
//   the output register frees up.
module anti_replay_window_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_remote_id,
   input  logic [31:0] req_seq,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_max_seq,
   output logic        rsp_initialized
);
   import arwf_pkg::*;

   state_type state_ff;
   state_type state_in;
   item_type  item_ff;
   rec_type   rec;
   wr_type    chk_wr;
   wr_type    mem_wr;
   rsp_type   chk_rsp;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_take;
   logic      out_free;
   logic      out_load;

   // hand a free output register to the checked word, or drain on handoff
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (out_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_stall = 1'b0;
         end
         STATE_EXEC: begin
            out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_take = req_valid && !req_stall;

   // commit the record only when the response is loaded
   always_comb begin
      mem_wr    = chk_wr;
      mem_wr.en = chk_wr.en && out_load;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request word and the response word
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd       <= req_cmd;
         item_ff.remote_id <= req_remote_id;
         item_ff.seq       <= req_seq;
      end
      if (out_load) begin
         rsp_ff <= chk_rsp;
      end
   end

   arwf_rec_mem u_rec_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_take),
      .rd_idx (IDX_W'(req_remote_id - 8'd1)),
      .rd_rec (rec),
      .wr     (mem_wr)
   );

   arwf_check u_check (
      .item (item_ff),
      .rec  (rec),
      .wr   (chk_wr),
      .rsp  (chk_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_ff.accepted;
   assign rsp_status      = rsp_ff.status;
   assign rsp_max_seq     = rsp_ff.max_seq;
   assign rsp_initialized = rsp_ff.initialized;

endmodule
